// ===== rtl/llst_pkg.sv =====
// Shared types and constants for the least-loaded server table.
`default_nettype none

package llst_pkg;

  localparam int SLOTS  = 16;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int ID_W   = 16;
  localparam int KIND_W = 4;
  localparam int LOAD_W = 16;

  localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

  // Request codes.
  localparam logic [2:0] REQ_ADD     = 3'd0;
  localparam logic [2:0] REQ_REMOVE  = 3'd1;
  localparam logic [2:0] REQ_SELECT  = 3'd2;
  localparam logic [2:0] REQ_RELEASE = 3'd3;
  localparam logic [2:0] REQ_LOOKUP  = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [ID_W-1:0]   conn_id;
    logic [ID_W-1:0]   server_id;
    logic [KIND_W-1:0] server_kind;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] result_id;
    logic [1:0]      status;
  } out_item_t;

  // Search keys shared by every cell during a scan.
  typedef struct packed {
    logic [ID_W-1:0]   conn;
    logic [ID_W-1:0]   server;
    logic [KIND_W-1:0] login;
  } cell_key_t;

  // Token that walks the row, one cell per cycle, collecting search results.
  typedef struct packed {
    logic              valid;
    logic              match;
    logic [IDX_W-1:0]  match_idx;
    logic              free;
    logic [IDX_W-1:0]  free_idx;
    logic              best;
    logic [IDX_W-1:0]  best_idx;
    logic [LOAD_W-1:0] best_load;
    logic [ID_W-1:0]   best_conn;
    logic              srv;
    logic [ID_W-1:0]   srv_conn;
  } scan_tok_t;

  typedef enum logic [1:0] {
    UPD_WRITE,
    UPD_CLEAR,
    UPD_INC,
    UPD_DEC
  } upd_op_t;

  // Update broadcast to the row; only the addressed cell applies it.
  typedef struct packed {
    logic              en;
    upd_op_t           op;
    logic [IDX_W-1:0]  idx;
    logic [ID_W-1:0]   conn;
    logic [ID_W-1:0]   server;
    logic [KIND_W-1:0] kind;
  } upd_t;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_SCAN,
    CTL_FINISH
  } ctl_state_t;

endpackage

`default_nettype wire

// ===== rtl/llst_cell.sv =====
// One table slot with its stage of the search token chain.
`default_nettype none

module llst_cell (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire  logic [llst_pkg::IDX_W-1:0]  my_idx,
  input  wire  llst_pkg::cell_key_t         key,
  input  wire  llst_pkg::scan_tok_t         tok_in,
  output llst_pkg::scan_tok_t               tok_out,
  input  wire  llst_pkg::upd_t              upd
);

  logic                          valid_r, valid_nxt;
  logic [llst_pkg::ID_W-1:0]     conn_r, conn_nxt;
  logic [llst_pkg::ID_W-1:0]     server_r, server_nxt;
  logic [llst_pkg::KIND_W-1:0]   kind_r, kind_nxt;
  logic [llst_pkg::LOAD_W-1:0]   load_r, load_nxt;
  llst_pkg::scan_tok_t           tok_r, tok_nxt;

  // Fold this slot into the passing token.
  always_comb begin
    tok_nxt = tok_in;
    if (valid_r && conn_r == key.conn && !tok_in.match) begin
      tok_nxt.match     = 1'b1;
      tok_nxt.match_idx = my_idx;
    end
    if (!valid_r && !tok_in.free) begin
      tok_nxt.free     = 1'b1;
      tok_nxt.free_idx = my_idx;
    end
    // Strict less-than keeps ties on the lower slot.
    if (valid_r && kind_r == key.login && (!tok_in.best || load_r < tok_in.best_load)) begin
      tok_nxt.best      = 1'b1;
      tok_nxt.best_idx  = my_idx;
      tok_nxt.best_load = load_r;
      tok_nxt.best_conn = conn_r;
    end
    if (valid_r && server_r == key.server && !tok_in.srv) begin
      tok_nxt.srv      = 1'b1;
      tok_nxt.srv_conn = conn_r;
    end
  end

  always_comb begin
    valid_nxt  = valid_r;
    conn_nxt   = conn_r;
    server_nxt = server_r;
    kind_nxt   = kind_r;
    load_nxt   = load_r;
    if (upd.en && upd.idx == my_idx) begin
      case (upd.op)
        llst_pkg::UPD_WRITE: begin
          valid_nxt  = 1'b1;
          conn_nxt   = upd.conn;
          server_nxt = upd.server;
          kind_nxt   = upd.kind;
          load_nxt   = '0;
        end
        llst_pkg::UPD_CLEAR: begin
          valid_nxt = 1'b0;
        end
        llst_pkg::UPD_INC: begin
          if (load_r != llst_pkg::LOAD_MAX) begin
            load_nxt = load_r + llst_pkg::LOAD_W'(1);
          end
        end
        llst_pkg::UPD_DEC: begin
          if (load_r != '0) begin
            load_nxt = load_r - llst_pkg::LOAD_W'(1);
          end
        end
        default: begin
          valid_nxt = valid_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    conn_r   <= conn_nxt;
    server_r <= server_nxt;
    kind_r   <= kind_nxt;
    load_r   <= load_nxt;
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

// ===== rtl/least_loaded_server_table.sv =====
// Top level: request control and the row of slot cells.
//
// Requests arrive on in_valid/in_data and are taken when in_stall is low.
// Each request gives exactly one result beat on out_valid/out_data.
// The block works on one request at a time: after a beat is accepted, a
// search token runs through the row of SLOTS cells, one cell per cycle,
// then the chosen slot is updated and the result is registered.
// The token passes the start register and the SLOTS cell registers, is
// held in the token register for the finish step, and the block takes no
// new request until the finish step has registered the result.
// If the receiver stalls, the finished result waits in the output
// register; a following request runs its scan and then holds its update
// and result until the output register is free.
// The user must write the login type register through cfg_we/cfg_wdata
// only while no request is in flight; the block does not enforce this.
// Reset empties every slot, clears the login type to zero and leaves the
// block ready for a request in the next cycle.
`default_nettype none

module least_loaded_server_table (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  llst_pkg::in_item_t         in_data,
  output logic                             out_valid,
  input  wire                              out_stall,
  output llst_pkg::out_item_t              out_data,
  input  wire                              cfg_we,
  input  wire  logic [llst_pkg::KIND_W-1:0] cfg_wdata
);

  llst_pkg::ctl_state_t          state_r, state_nxt;
  llst_pkg::in_item_t            req_r;
  llst_pkg::scan_tok_t           tok_r, tok_nxt;
  logic                          start_r;
  logic [llst_pkg::KIND_W-1:0]   login_r;
  logic                          out_valid_r, out_valid_nxt;
  llst_pkg::out_item_t           out_data_r, out_data_nxt;
  llst_pkg::upd_t                upd;
  llst_pkg::cell_key_t           key;
  llst_pkg::scan_tok_t           launch;
  llst_pkg::scan_tok_t           tok_chain [llst_pkg::SLOTS+1];
  logic                          in_acc;
  logic                          out_free;

  assign in_stall  = (state_r != llst_pkg::CTL_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign key.conn   = req_r.conn_id;
  assign key.server = req_r.server_id;
  assign key.login  = login_r;

  always_comb begin
    launch       = '0;
    launch.valid = start_r;
  end

  assign tok_chain[0] = launch;

  for (genvar i = 0; i < llst_pkg::SLOTS; i++) begin : g_cell
    llst_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .my_idx  (llst_pkg::IDX_W'(i)),
      .key     (key),
      .tok_in  (tok_chain[i]),
      .tok_out (tok_chain[i+1]),
      .upd     (upd)
    );
  end

  always_comb begin
    state_nxt     = state_r;
    tok_nxt       = tok_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    upd           = '0;
    upd.conn      = req_r.conn_id;
    upd.server    = req_r.server_id;
    upd.kind      = req_r.server_kind;
    case (state_r)
      llst_pkg::CTL_IDLE: begin
        if (in_acc) begin
          state_nxt = llst_pkg::CTL_SCAN;
        end
      end
      llst_pkg::CTL_SCAN: begin
        if (tok_chain[llst_pkg::SLOTS].valid) begin
          tok_nxt   = tok_chain[llst_pkg::SLOTS];
          state_nxt = llst_pkg::CTL_FINISH;
        end
      end
      llst_pkg::CTL_FINISH: begin
        if (out_free) begin
          state_nxt              = llst_pkg::CTL_IDLE;
          out_valid_nxt          = 1'b1;
          out_data_nxt.result_id = '0;
          out_data_nxt.status    = llst_pkg::ST_MISS;
          case (req_r.req_type)
            llst_pkg::REQ_ADD: begin
              if (tok_r.match || tok_r.free) begin
                upd.en                 = 1'b1;
                upd.op                 = llst_pkg::UPD_WRITE;
                upd.idx                = tok_r.match ? tok_r.match_idx : tok_r.free_idx;
                out_data_nxt.result_id = req_r.conn_id;
                out_data_nxt.status    = llst_pkg::ST_DONE;
              end else begin
                out_data_nxt.status = llst_pkg::ST_FULL;
              end
            end
            llst_pkg::REQ_REMOVE: begin
              if (tok_r.match) begin
                upd.en                 = 1'b1;
                upd.op                 = llst_pkg::UPD_CLEAR;
                upd.idx                = tok_r.match_idx;
                out_data_nxt.result_id = req_r.conn_id;
                out_data_nxt.status    = llst_pkg::ST_DONE;
              end
            end
            llst_pkg::REQ_SELECT: begin
              if (tok_r.match) begin
                upd.en                 = 1'b1;
                upd.op                 = llst_pkg::UPD_INC;
                upd.idx                = tok_r.match_idx;
                out_data_nxt.result_id = req_r.conn_id;
                out_data_nxt.status    = llst_pkg::ST_DONE;
              end else if (tok_r.best) begin
                upd.en                 = 1'b1;
                upd.op                 = llst_pkg::UPD_INC;
                upd.idx                = tok_r.best_idx;
                out_data_nxt.result_id = tok_r.best_conn;
                out_data_nxt.status    = llst_pkg::ST_DONE;
              end
            end
            llst_pkg::REQ_RELEASE: begin
              if (tok_r.match) begin
                upd.en                 = 1'b1;
                upd.op                 = llst_pkg::UPD_DEC;
                upd.idx                = tok_r.match_idx;
                out_data_nxt.result_id = req_r.conn_id;
                out_data_nxt.status    = llst_pkg::ST_DONE;
              end
            end
            llst_pkg::REQ_LOOKUP: begin
              if (tok_r.srv) begin
                out_data_nxt.result_id = tok_r.srv_conn;
                out_data_nxt.status    = llst_pkg::ST_DONE;
              end
            end
            default: begin
              out_data_nxt.status = llst_pkg::ST_MISS;
            end
          endcase
        end
      end
      default: begin
        state_nxt = llst_pkg::CTL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= llst_pkg::CTL_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      login_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= in_acc;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        login_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_r      <= tok_nxt;
    out_data_r <= out_data_nxt;
    if (in_acc) begin
      req_r <= in_data;
    end
  end

  // A token leaves the row only while a scan is running.
  a_tok_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok_chain[llst_pkg::SLOTS].valid |-> state_r == llst_pkg::CTL_SCAN)
    else $error("scan token left the row outside a scan");

  // An accepted beat always launches a token.
  a_accept_launch: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> start_r && state_r == llst_pkg::CTL_SCAN)
    else $error("accepted request did not start a scan");

  // A new result is only loaded when a request finishes.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == llst_pkg::CTL_FINISH))
    else $error("result appeared without a finished request");

  // The finish step is only entered from a scan.
  a_finish_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == llst_pkg::CTL_FINISH |->
      $past(state_r == llst_pkg::CTL_SCAN) || $past(state_r == llst_pkg::CTL_FINISH))
    else $error("finish step entered out of order");

endmodule

`default_nettype wire
